// ----- rtl/ase_pkg.sv -----
// ----------------------------------------------------------------------------
// ASCII string extractor package
// Register indexes, register reset values and the configuration bundle shared
// by the register file and the run tracker.
// ----------------------------------------------------------------------------
package ase_pkg;

    // Register indexes on the configuration port.
    localparam int CFG_INDEX_W = 2;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MIN_LENGTH  = 2'd0,
        CFG_FILL_VALUES = 2'd1,
        CFG_FILL_USED   = 2'd2
    } cfg_index_t;

    localparam int CFG_DATA_W = 32;

    // Field widths of the registers and of the beats.
    localparam int MIN_LEN_W   = 16;
    localparam int FILL_VAL_W  = 32;
    localparam int FILL_USED_W = 3;
    localparam int BYTE_W      = 8;
    localparam int OUT_W       = 32;
    localparam int FILL_SLOTS  = 4;

    // Register values after reset.
    localparam logic [MIN_LEN_W-1:0]   MIN_LEN_RST   = 16'd4;
    localparam logic [FILL_VAL_W-1:0]  FILL_VAL_RST  = 32'h0000_FF00;
    localparam logic [FILL_USED_W-1:0] FILL_USED_RST = 3'd2;

    // Printable range.
    localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
    localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7E;

    // Configuration bundle from the register file to the tracker.
    typedef struct packed {
        logic [MIN_LEN_W-1:0]   min_length;
        logic [FILL_VAL_W-1:0]  fill_values;
        logic [FILL_USED_W-1:0] fill_used;
    } cfg_t;

endpackage

// ----- rtl/ase_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// ASCII string extractor configuration registers
// Holds the minimum run length and the fill filter settings, written through a
// plain write port.
// ----------------------------------------------------------------------------
module ase_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [ase_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ase_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output ase_pkg::cfg_t                     cfg
);

    ase_pkg::cfg_t cfg_reg;
    ase_pkg::cfg_t cfg_next;

    // Decode the write and update the addressed register.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                ase_pkg::CFG_MIN_LENGTH: begin
                    cfg_next.min_length = cfg_wdata[ase_pkg::MIN_LEN_W-1:0];
                end
                ase_pkg::CFG_FILL_VALUES: begin
                    cfg_next.fill_values = cfg_wdata[ase_pkg::FILL_VAL_W-1:0];
                end
                ase_pkg::CFG_FILL_USED: begin
                    cfg_next.fill_used = cfg_wdata[ase_pkg::FILL_USED_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_length  <= ase_pkg::MIN_LEN_RST;
            cfg_reg.fill_values <= ase_pkg::FILL_VAL_RST;
            cfg_reg.fill_used   <= ase_pkg::FILL_USED_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/ase_in_reg.sv -----
// ----------------------------------------------------------------------------
// ASCII string extractor input register
// Captures one input beat and holds it until the tracker consumes it.
// ----------------------------------------------------------------------------
module ase_in_reg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ase_pkg::BYTE_W-1:0]    s_data_byte,
    input  logic                          s_final_byte,
    input  logic                          advance,
    output logic                          held_valid,
    output logic [ase_pkg::BYTE_W-1:0]    held_data,
    output logic                          held_final
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [ase_pkg::BYTE_W-1:0] data_reg;
    logic                       final_reg;

    // The register frees up in the same cycle that its beat moves on.
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload is loaded on every accepted beat.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg  <= s_data_byte;
            final_reg <= s_final_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_data  = data_reg;
    assign held_final = final_reg;

endmodule

// ----- rtl/ase_tracker.sv -----
// ----------------------------------------------------------------------------
// ASCII string extractor run tracker
// Keeps the byte position, the open run and the fill match flags, and judges
// each run as it ends.
// ----------------------------------------------------------------------------
module ase_tracker #(
    parameter int HALF_WINDOW = 32,
    parameter int POS_BITS    = 32,
    parameter int MAX_FILLS   = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [ase_pkg::BYTE_W-1:0]    data_byte,
    input  logic                          final_byte,
    input  ase_pkg::cfg_t                 cfg,
    output logic                          res_valid,
    output logic [ase_pkg::OUT_W-1:0]     res_offset,
    output logic [ase_pkg::OUT_W-1:0]     res_length
);

    // Fill slots that really take part, and the widths used for compares.
    localparam int ACT_FILLS = (MAX_FILLS < ase_pkg::FILL_SLOTS) ? MAX_FILLS
                                                                  : ase_pkg::FILL_SLOTS;
    localparam int WIN_W     = (POS_BITS > 18) ? POS_BITS : 18;
    localparam int LEN_CMP_W = (POS_BITS > ase_pkg::MIN_LEN_W) ? POS_BITS
                                                                : ase_pkg::MIN_LEN_W;
    localparam int EXT_W     = (POS_BITS > ase_pkg::OUT_W) ? POS_BITS : ase_pkg::OUT_W;
    localparam logic [WIN_W-1:0] HALF_WIN_V = WIN_W'(HALF_WINDOW);

    logic [POS_BITS-1:0]  pos_reg;
    logic [POS_BITS-1:0]  pos_next;
    logic [POS_BITS-1:0]  begin_reg;
    logic [POS_BITS-1:0]  begin_next;
    logic                 active_reg;
    logic                 active_next;
    logic [MAX_FILLS-1:0] flags_reg;
    logic [MAX_FILLS-1:0] flags_next;

    logic                 printable;
    logic                 in_window;
    logic [MAX_FILLS-1:0] flags_upd;
    logic [MAX_FILLS-1:0] use_mask;
    logic [ase_pkg::FILL_USED_W-1:0] fills_n;
    logic [POS_BITS-1:0]  pos_inc;
    logic [POS_BITS-1:0]  run_origin;
    logic [POS_BITS-1:0]  end_pos;
    logic [POS_BITS-1:0]  run_len;
    logic                 closing;
    logic                 too_short;
    logic                 dropped;
    logic [EXT_W-1:0]     off_ext;
    logic [EXT_W-1:0]     len_ext;

    // Classify the byte and test whether it falls inside the fill window.
    assign printable = (data_byte >= ase_pkg::PRINT_LO) && (data_byte <= ase_pkg::PRINT_HI);
    assign in_window = WIN_W'(pos_reg) < HALF_WIN_V;
    assign pos_inc   = pos_reg + POS_BITS'(1);

    // Inside the fill window, clear the flag of every fill byte that this byte does not match.
    always_comb begin
        flags_upd = flags_reg;
        for (int k = 0; k < ACT_FILLS; k++) begin
            if (in_window &&
                (cfg.fill_values[8*(k%ase_pkg::FILL_SLOTS) +: ase_pkg::BYTE_W]
                 != data_byte)) begin
                flags_upd[k] = 1'b0;
            end
        end
    end

    // Number of fill bytes in use, capped at the slots present, as a mask.
    always_comb begin
        fills_n = cfg.fill_used;
        if (fills_n > ase_pkg::FILL_USED_W'(ACT_FILLS)) begin
            fills_n = ase_pkg::FILL_USED_W'(ACT_FILLS);
        end
        for (int k = 0; k < MAX_FILLS; k++) begin
            use_mask[k] = (k < ACT_FILLS) && (ase_pkg::FILL_USED_W'(k) < fills_n);
        end
    end

    // A run starts here when none is open; it ends on a non-printable byte or
    // at the final byte, the latter including that byte.
    assign run_origin = active_reg ? begin_reg : pos_reg;
    assign closing    = printable ? final_byte : active_reg;
    assign end_pos    = printable ? pos_inc : pos_reg;
    assign run_len    = end_pos - run_origin;
    assign too_short  = LEN_CMP_W'(run_len) < LEN_CMP_W'(cfg.min_length);
    assign dropped    = (HALF_WINDOW != 0) && (run_origin == '0) && |(flags_upd & use_mask);

    assign res_valid = closing && (cfg.min_length != '0) && !too_short && !dropped;
    assign off_ext   = EXT_W'(run_origin);
    assign len_ext   = EXT_W'(run_len);
    assign res_offset = off_ext[ase_pkg::OUT_W-1:0];
    assign res_length = len_ext[ase_pkg::OUT_W-1:0];

    // State update; everything returns to reset after the final byte.
    always_comb begin
        pos_next    = pos_reg;
        begin_next  = begin_reg;
        active_next = active_reg;
        flags_next  = flags_reg;
        if (step) begin
            if (final_byte) begin
                pos_next    = '0;
                begin_next  = '0;
                active_next = 1'b0;
                flags_next  = '1;
            end else begin
                pos_next    = pos_inc;
                begin_next  = (printable && !active_reg) ? pos_reg : begin_reg;
                active_next = printable;
                flags_next  = flags_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            begin_reg  <= '0;
            active_reg <= 1'b0;
            flags_reg  <= '1;
        end else begin
            pos_reg    <= pos_next;
            begin_reg  <= begin_next;
            active_reg <= active_next;
            flags_reg  <= flags_next;
        end
    end

endmodule

// ----- rtl/ascii_string_extractor.sv -----
// ----------------------------------------------------------------------------
// ASCII string extractor
// Finds runs of printable ASCII in a byte stream and reports offset and length.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle as long as no result is held back by
// m_ready. A byte is captured in an input register and judged by the run tracker
// once the output register can take its result; the result then goes to that
// output register. The output register holds a waiting result; while m_ready
// holds it back the tracker stalls, and a further byte is accepted only if the
// input register is empty. Only a result held back by m_ready stalls the input.
// Configuration is written with cfg_wr_en, cfg_index and cfg_wdata while no
// buffer is in flight.
module ascii_string_extractor #(
    parameter int HALF_WINDOW = 32,
    parameter int POS_BITS    = 32,
    parameter int MAX_FILLS   = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [ase_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ase_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ase_pkg::BYTE_W-1:0]        s_data_byte,
    input  logic                              s_final_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ase_pkg::OUT_W-1:0]         m_str_offset,
    output logic [ase_pkg::OUT_W-1:0]         m_str_length
);

    ase_pkg::cfg_t              cfg;
    logic                       held_valid;
    logic [ase_pkg::BYTE_W-1:0] held_data;
    logic                       held_final;
    logic                       step;
    logic                       res_valid;
    logic [ase_pkg::OUT_W-1:0]  res_offset;
    logic [ase_pkg::OUT_W-1:0]  res_length;
    logic                       m_valid_reg;
    logic                       m_valid_next;
    logic [ase_pkg::OUT_W-1:0]  m_offset_reg;
    logic [ase_pkg::OUT_W-1:0]  m_length_reg;

    ase_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ase_in_reg u_in_reg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_final_byte (s_final_byte),
        .advance      (step),
        .held_valid   (held_valid),
        .held_data    (held_data),
        .held_final   (held_final)
    );

    // A held byte is processed when the output register can take its result.
    assign step = held_valid && (!m_valid_reg || m_ready);

    ase_tracker #(
        .HALF_WINDOW (HALF_WINDOW),
        .POS_BITS    (POS_BITS),
        .MAX_FILLS   (MAX_FILLS)
    ) u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .data_byte  (held_data),
        .final_byte (held_final),
        .cfg        (cfg),
        .res_valid  (res_valid),
        .res_offset (res_offset),
        .res_length (res_length)
    );

    // Output register: loads on every step, empties when its beat is taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (step) begin
            m_valid_next = res_valid;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            m_offset_reg <= res_offset;
            m_length_reg <= res_length;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_str_offset = m_offset_reg;
    assign m_str_length = m_length_reg;

endmodule

// ----- rtl/ase_checker.sv -----
// ----------------------------------------------------------------------------
// ASCII string extractor port checker
// Watches the top-level ports over time and flags behaviour that the block
// must never show.
// ----------------------------------------------------------------------------
module ase_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_ready,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [ase_pkg::OUT_W-1:0]     m_str_offset,
    input  logic [ase_pkg::OUT_W-1:0]     m_str_length
);

    // No result beat is shown straight after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat shown after reset");

    // The input side is ready straight after reset.
    assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // A reported run always holds at least one byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_str_length != '0))
        else $error("empty run reported");

    // A stalled result beat keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_str_offset) && $stable(m_str_length)))
        else $error("stalled result beat changed");

endmodule

bind ascii_string_extractor ase_checker u_ase_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_str_offset (m_str_offset),
    .m_str_length (m_str_length)
);
